// ----- hdl/brpm_pkg.sv -----
// Shared types and constants for the banked RAM port mapper.
package brpm_pkg;

    localparam int NUM_PORTS = 4;
    localparam int Q_DEPTH   = 2;

    localparam logic [15:0] SHIFT_BLOCK_MASK = 16'h1AE0;

    localparam int CTL_OFF_BASE_6_BIT = 6;
    localparam int CTL_OFF_BASE_A_BIT = 5;
    localparam int CTL_INC_BASE_BIT   = 4;
    localparam int CTL_USE_OFFSET_BIT = 1;
    localparam int CTL_ENABLE_INC_BIT = 0;

    localparam logic [3:0] PREG_DATA0   = 4'd0;
    localparam logic [3:0] PREG_DATA1   = 4'd1;
    localparam logic [3:0] PREG_BASE0   = 4'd2;
    localparam logic [3:0] PREG_BASE1   = 4'd3;
    localparam logic [3:0] PREG_BASE2   = 4'd4;
    localparam logic [3:0] PREG_OFF0    = 4'd5;
    localparam logic [3:0] PREG_OFF1    = 4'd6;
    localparam logic [3:0] PREG_STEP0   = 4'd7;
    localparam logic [3:0] PREG_STEP1   = 4'd8;
    localparam logic [3:0] PREG_CONTROL = 4'd9;
    localparam logic [3:0] PREG_ADD_OFF = 4'd10;

    localparam logic [3:0] SREG_LANE0  = 4'd0;
    localparam logic [3:0] SREG_LANE1  = 4'd1;
    localparam logic [3:0] SREG_LANE2  = 4'd2;
    localparam logic [3:0] SREG_LANE3  = 4'd3;
    localparam logic [3:0] SREG_AMOUNT = 4'd4;
    localparam logic [3:0] SREG_SPARE  = 4'd5;
    localparam logic [3:0] SREG_ID0    = 4'd14;
    localparam logic [3:0] SREG_ID1    = 4'd15;

    localparam logic [7:0] ID0_BYTE  = 8'h10;
    localparam logic [7:0] ID1_BYTE  = 8'h51;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef logic [$clog2(NUM_PORTS)-1:0] t_port_idx;

    typedef struct packed {
        logic       is_shift;
        logic       wr;
        t_port_idx  port;
        logic [3:0] reg_sel;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/brpm_front.sv -----
// Front end: accepts bus requests and classifies them by address.
module brpm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_cmd,
    input  logic [15:0]   i_bus_address,
    input  logic [7:0]    i_write_byte,
    input  logic          i_q_full,
    output logic          o_req_valid,
    output brpm_pkg::t_req o_req
);
    import brpm_pkg::*;

    logic r_valid;
    t_req r_req;
    t_req n_req;
    logic take;

    assign o_stall     = r_valid && i_q_full;
    assign take        = i_valid && !o_stall;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_comb begin
        n_req.is_shift = (i_bus_address & SHIFT_BLOCK_MASK) == SHIFT_BLOCK_MASK;
        n_req.wr       = i_cmd;
        n_req.port     = i_bus_address[5:4];
        n_req.reg_sel  = i_bus_address[3:0];
        n_req.data     = i_write_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_req <= n_req;
        end
    end

endmodule

// ----- hdl/brpm_queue.sv -----
// Short request queue between the front end and the back end.
module brpm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    input  brpm_pkg::t_req     i_push_req,
    input  logic               i_pop,
    output brpm_pkg::t_req     o_head,
    output brpm_pkg::t_q_status o_status
);
    import brpm_pkg::*;

    localparam int PTR_BITS = $clog2(Q_DEPTH);
    localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

    t_req                r_mem [Q_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                push;

    assign o_status.full  = r_count == CNT_BITS'(Q_DEPTH);
    assign o_status.empty = r_count == '0;
    assign push           = i_push_valid && !o_status.full;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

// ----- hdl/brpm_back.sv -----
// Back end: shift block, port registers, card RAM and result output.
module brpm_back #(
    parameter int RAM_ADDR_BITS = 21
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  brpm_pkg::t_req i_req,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_read_byte
);
    import brpm_pkg::*;

    localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

    logic [31:0] r_shift_value;
    logic [3:0]  r_shift_amount;
    logic [7:0]  r_spare_byte;
    logic [23:0] r_base    [NUM_PORTS];
    logic [15:0] r_offset  [NUM_PORTS];
    logic [15:0] r_step    [NUM_PORTS];
    logic [7:0]  r_control [NUM_PORTS];

    logic [7:0]  r_ram [RAM_DEPTH];
    logic [7:0]  r_ram_q;

    logic        r_s1_valid;
    logic        r_s1_from_ram;
    logic [7:0]  r_s1_byte;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;

    logic        s1_move;
    logic        issue;
    logic        is_data;
    logic        ram_wr;
    logic        ram_rd;
    logic [23:0] cur_base;
    logic [15:0] cur_offset;
    logic [15:0] cur_step;
    logic [7:0]  cur_control;
    logic [23:0] base_plus_off;
    logic [RAM_ADDR_BITS-1:0] ram_addr;

    logic [23:0] n_base;
    logic [15:0] n_offset;
    logic [15:0] n_step;
    logic [7:0]  n_control;
    logic [31:0] n_shift_value;
    logic [3:0]  n_shift_amount;
    logic [7:0]  n_spare_byte;
    logic [7:0]  n_byte;
    logic [3:0]  amt;
    logic [4:0]  right_amt;

    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign issue   = i_req_valid && (!r_s1_valid || s1_move);
    assign o_pop   = issue;
    assign o_valid = r_out_valid;
    assign o_read_byte = r_out_byte;

    assign cur_base      = r_base[i_req.port];
    assign cur_offset    = r_offset[i_req.port];
    assign cur_step      = r_step[i_req.port];
    assign cur_control   = r_control[i_req.port];
    assign base_plus_off = cur_base + {8'd0, cur_offset};
    assign ram_addr      = cur_control[CTL_USE_OFFSET_BIT] ?
                           base_plus_off[RAM_ADDR_BITS-1:0] : cur_base[RAM_ADDR_BITS-1:0];
    assign is_data = !i_req.is_shift &&
                     (i_req.reg_sel == PREG_DATA0 || i_req.reg_sel == PREG_DATA1);
    assign ram_wr  = issue && is_data && i_req.wr;
    assign ram_rd  = issue && is_data && !i_req.wr;

    assign amt       = i_req.data[3:0];
    assign right_amt = 5'd16 - {1'b0, amt};

    always_comb begin
        n_base    = cur_base;
        n_offset  = cur_offset;
        n_step    = cur_step;
        n_control = cur_control;
        if (is_data) begin
            if (cur_control[CTL_ENABLE_INC_BIT]) begin
                if (cur_control[CTL_INC_BASE_BIT]) begin
                    n_base = cur_base + {8'd0, cur_step};
                end else begin
                    n_offset = cur_offset + cur_step;
                end
            end
        end else if (i_req.wr) begin
            unique case (i_req.reg_sel)
                PREG_BASE0:   n_base    = {cur_base[23:8], i_req.data};
                PREG_BASE1:   n_base    = {cur_base[23:16], i_req.data, cur_base[7:0]};
                PREG_BASE2:   n_base    = {i_req.data, cur_base[15:0]};
                PREG_OFF0:    n_offset  = {cur_offset[15:8], i_req.data};
                PREG_OFF1: begin
                    n_offset = {i_req.data, cur_offset[7:0]};
                    if (cur_control[CTL_OFF_BASE_6_BIT]) begin
                        n_base = cur_base + {8'd0, i_req.data, cur_offset[7:0]};
                    end
                end
                PREG_STEP0:   n_step    = {cur_step[15:8], i_req.data};
                PREG_STEP1:   n_step    = {i_req.data, cur_step[7:0]};
                PREG_CONTROL: n_control = i_req.data;
                PREG_ADD_OFF: begin
                    if (cur_control[CTL_OFF_BASE_6_BIT] && cur_control[CTL_OFF_BASE_A_BIT]) begin
                        n_base = base_plus_off;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_shift_value  = r_shift_value;
        n_shift_amount = r_shift_amount;
        n_spare_byte   = r_spare_byte;
        if (i_req.wr) begin
            unique case (i_req.reg_sel)
                SREG_LANE0: n_shift_value = {r_shift_value[31:8], i_req.data};
                SREG_LANE1: n_shift_value = {r_shift_value[31:16], i_req.data,
                                             r_shift_value[7:0]};
                SREG_LANE2: n_shift_value = {r_shift_value[31:24], i_req.data,
                                             r_shift_value[15:0]};
                SREG_LANE3: n_shift_value = {i_req.data, r_shift_value[23:0]};
                SREG_AMOUNT: begin
                    n_shift_amount = amt;
                    if (amt != 4'd0) begin
                        if (!amt[3]) begin
                            n_shift_value = r_shift_value << amt;
                        end else begin
                            n_shift_value = r_shift_value >> right_amt;
                        end
                    end
                end
                SREG_SPARE: n_spare_byte = i_req.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_byte = 8'd0;
        if (!i_req.wr) begin
            if (i_req.is_shift) begin
                unique case (i_req.reg_sel)
                    SREG_LANE0:  n_byte = r_shift_value[7:0];
                    SREG_LANE1:  n_byte = r_shift_value[15:8];
                    SREG_LANE2:  n_byte = r_shift_value[23:16];
                    SREG_LANE3:  n_byte = r_shift_value[31:24];
                    SREG_AMOUNT: n_byte = {4'd0, r_shift_amount};
                    SREG_SPARE:  n_byte = r_spare_byte;
                    SREG_ID0:    n_byte = ID0_BYTE;
                    SREG_ID1:    n_byte = ID1_BYTE;
                    default:     n_byte = FILL_BYTE;
                endcase
            end else begin
                unique case (i_req.reg_sel)
                    PREG_DATA0, PREG_DATA1: n_byte = 8'd0;
                    PREG_BASE0:   n_byte = cur_base[7:0];
                    PREG_BASE1:   n_byte = cur_base[15:8];
                    PREG_BASE2:   n_byte = cur_base[23:16];
                    PREG_OFF0:    n_byte = cur_offset[7:0];
                    PREG_OFF1:    n_byte = cur_offset[15:8];
                    PREG_STEP0:   n_byte = cur_step[7:0];
                    PREG_STEP1:   n_byte = cur_step[15:8];
                    PREG_CONTROL: n_byte = cur_control;
                    PREG_ADD_OFF: n_byte = 8'd0;
                    default:      n_byte = FILL_BYTE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_wr) begin
            r_ram[ram_addr] <= i_req.data;
        end
        if (ram_rd) begin
            r_ram_q <= r_ram[ram_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_value  <= '0;
            r_shift_amount <= '0;
            r_spare_byte   <= '0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_base[i]    <= '0;
                r_offset[i]  <= '0;
                r_step[i]    <= '0;
                r_control[i] <= '0;
            end
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                if (i_req.is_shift) begin
                    r_shift_value  <= n_shift_value;
                    r_shift_amount <= n_shift_amount;
                    r_spare_byte   <= n_spare_byte;
                end else begin
                    r_base[i_req.port]    <= n_base;
                    r_offset[i_req.port]  <= n_offset;
                    r_step[i_req.port]    <= n_step;
                    r_control[i_req.port] <= n_control;
                end
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (issue) begin
            r_s1_from_ram <= ram_rd;
            r_s1_byte     <= n_byte;
        end
        if (s1_move) begin
            r_out_byte <= r_s1_from_ram ? r_ram_q : r_s1_byte;
        end
    end

endmodule

// ----- hdl/banked_ram_port_mapper_unit.sv -----
// Top level of the banked RAM port mapper: front end, request queue, back end.
// Each bus request (read or write at a 16-bit address) gives exactly one result byte, 0 for
// writes. The block sustains one request per clock while the output is not stalled. The
// request passes the front register, the queue, the issue stage with the card RAM access,
// and the output register. The card RAM is a single memory of 2^RAM_ADDR_BITS bytes with
// one access per clock and registered read data; its contents are undefined until written.
// Addresses matching mask 0x1AE0 reach the shift block, all others one of four ports.
module banked_ram_port_mapper_unit #(
    parameter int RAM_ADDR_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_byte
);
    import brpm_pkg::*;

    logic      front_valid;
    t_req      front_req;
    t_req      head_req;
    t_q_status q_status;
    logic      back_pop;

    brpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_bus_address (i_bus_address),
        .i_write_byte  (i_write_byte),
        .i_q_full      (q_status.full),
        .o_req_valid   (front_valid),
        .o_req         (front_req)
    );

    brpm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_req   (front_req),
        .i_pop        (back_pop),
        .o_head       (head_req),
        .o_status     (q_status)
    );

    brpm_back #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (!q_status.empty),
        .i_req       (head_req),
        .o_pop       (back_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_byte (o_read_byte)
    );

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> !q_status.empty)
        else $error("request popped from empty queue");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> q_status.full && front_valid)
        else $error("input stalled while queue has room");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("output active right after reset");
`endif

endmodule
